// ===== design/ithe_pkg.sv =====
package ithe_pkg;

  localparam int unsigned CountW          = 16;
  localparam int unsigned DefMaxFrameBytes = 65535;

  localparam int unsigned EthHdrLen   = 14;
  localparam int unsigned IpHdrLen    = 20;
  localparam int unsigned PosVersion  = 14;
  localparam int unsigned PosProtocol = 23;
  localparam int unsigned PosSrcIp    = 26;
  localparam int unsigned PosDstIp    = 30;
  localparam int unsigned PosSrcPort  = 34;
  localparam int unsigned PosDstPort  = 36;
  localparam int unsigned PosDataOff  = 46;

  localparam logic [7:0] ProtoTcp   = 8'd6;
  localparam logic [3:0] IpVersion4 = 4'd4;

  localparam int unsigned OffsetW = 7;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_NOT_IPV4 = 2'd1,
    ST_NOT_TCP  = 2'd2,
    ST_BAD_LEN  = 2'd3
  } status_e;

  typedef struct packed {
    status_e             status;
    logic [31:0]         src_ip;
    logic [31:0]         dst_ip;
    logic [15:0]         src_port;
    logic [15:0]         dst_port;
    logic [OffsetW-1:0]  payload_offset;
    logic [CountW-1:0]   payload_length;
  } result_t;

endpackage

// ===== design/ithe_parse.sv =====
module ithe_parse import ithe_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       take_i,
  input  logic [7:0] frame_byte_i,
  input  logic       last_byte_i,
  output result_t    result_o
);

  localparam logic [CountW-1:0] MaxCount = CountW'(MAX_FRAME_BYTES);

  logic [CountW-1:0] count_q, count_d;
  logic [3:0]        version_q, version_d;
  logic [7:0]        proto_q, proto_d;
  logic [31:0]       src_ip_q, src_ip_d;
  logic [31:0]       dst_ip_q, dst_ip_d;
  logic [15:0]       src_port_q, src_port_d;
  logic [15:0]       dst_port_q, dst_port_d;
  logic [3:0]        doff_q, doff_d;

  logic [CountW-1:0]  pos;
  logic [OffsetW-1:0] offset;

  assign pos = count_q;

  always_comb begin
    count_d    = count_q;
    version_d  = version_q;
    proto_d    = proto_q;
    src_ip_d   = src_ip_q;
    dst_ip_d   = dst_ip_q;
    src_port_d = src_port_q;
    dst_port_d = dst_port_q;
    doff_d     = doff_q;
    if (pos < MaxCount) begin
      priority if (pos == CountW'(PosVersion)) begin
        version_d = frame_byte_i[7:4];
      end else if (pos == CountW'(PosProtocol)) begin
        proto_d = frame_byte_i;
      end else if (pos >= CountW'(PosSrcIp) && pos < CountW'(PosSrcIp + 4)) begin
        src_ip_d = {src_ip_q[23:0], frame_byte_i};
      end else if (pos >= CountW'(PosDstIp) && pos < CountW'(PosDstIp + 4)) begin
        dst_ip_d = {dst_ip_q[23:0], frame_byte_i};
      end else if (pos >= CountW'(PosSrcPort) && pos < CountW'(PosSrcPort + 2)) begin
        src_port_d = {src_port_q[7:0], frame_byte_i};
      end else if (pos >= CountW'(PosDstPort) && pos < CountW'(PosDstPort + 2)) begin
        dst_port_d = {dst_port_q[7:0], frame_byte_i};
      end else if (pos == CountW'(PosDataOff)) begin
        doff_d = frame_byte_i[7:4];
      end else begin
      end
      count_d = pos + CountW'(1);
    end
  end

  // offset = 34 + 4 * data offset, at most 94
  assign offset = OffsetW'(EthHdrLen + IpHdrLen) + {1'b0, doff_d, 2'b00};

  always_comb begin
    status_e st;
    st = ST_OK;
    priority if (count_d <= CountW'(PosVersion)) begin
      st = ST_BAD_LEN;
    end else if (version_d != IpVersion4) begin
      st = ST_NOT_IPV4;
    end else if (count_d <= CountW'(PosProtocol)) begin
      st = ST_BAD_LEN;
    end else if (proto_d != ProtoTcp) begin
      st = ST_NOT_TCP;
    end else if (count_d <= CountW'(PosDataOff)) begin
      st = ST_BAD_LEN;
    end else if (CountW'(offset) >= count_d) begin
      st = ST_BAD_LEN;
    end else begin
      st = ST_OK;
    end

    result_o = '0;
    result_o.status = st;
    if (st == ST_OK) begin
      result_o.src_ip         = src_ip_d;
      result_o.dst_ip         = dst_ip_d;
      result_o.src_port       = src_port_d;
      result_o.dst_port       = dst_port_d;
      result_o.payload_offset = offset;
      result_o.payload_length = count_d - CountW'(offset);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      version_q  <= '0;
      proto_q    <= '0;
      src_ip_q   <= '0;
      dst_ip_q   <= '0;
      src_port_q <= '0;
      dst_port_q <= '0;
      doff_q     <= '0;
    end else if (take_i) begin
      if (last_byte_i) begin
        count_q    <= '0;
        version_q  <= '0;
        proto_q    <= '0;
        src_ip_q   <= '0;
        dst_ip_q   <= '0;
        src_port_q <= '0;
        dst_port_q <= '0;
        doff_q     <= '0;
      end else begin
        count_q    <= count_d;
        version_q  <= version_d;
        proto_q    <= proto_d;
        src_ip_q   <= src_ip_d;
        dst_ip_q   <= dst_ip_d;
        src_port_q <= src_port_d;
        dst_port_q <= dst_port_d;
        doff_q     <= doff_d;
      end
    end
  end

endmodule

// ===== design/ipv4_tcp_header_extractor.sv =====
// Ethernet/IPv4/TCP header extractor.
// Input channel (in_valid_i/in_ready_o): one frame byte per item, starting at
// the Ethernet header, with last_byte_i set on the final byte of the frame.
// Output channel (out_valid_o/out_ready_i): one result per frame, issued for
// the item that carries last_byte_i: status, addresses, ports, payload
// offset and payload length. Rejected frames report zero in every field but
// status.
// Throughput: one byte per cycle, but for the last-byte wait below. Latency:
// the result is valid in the cycle after the last byte is taken. Header
// fields are captured as bytes arrive; the final checks are combinational.
// When the receiver stalls, the result waits in the output register; bytes
// keep being taken, and a frame's last byte waits only while the output
// register is full and not being drained.
// Reset clears the byte counter, all captured header fields and the output
// valid flag; the block is ready for a new frame right after reset.
module ipv4_tcp_header_extractor import ithe_pkg::*; #(
  parameter int unsigned MAX_FRAME_BYTES = DefMaxFrameBytes
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         frame_byte_i,
  input  logic               last_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [31:0]        src_ip_o,
  output logic [31:0]        dst_ip_o,
  output logic [15:0]        src_port_o,
  output logic [15:0]        dst_port_o,
  output logic [OffsetW-1:0] payload_offset_o,
  output logic [CountW-1:0]  payload_length_o
);

  result_t res_d, res_q;
  logic    out_valid_q;
  logic    take;
  logic    slot_free;

  assign slot_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = slot_free || !last_byte_i;
  assign take       = in_valid_i && in_ready_o;

  ithe_parse #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_parse (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .frame_byte_i(frame_byte_i),
    .last_byte_i (last_byte_i),
    .result_o    (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && last_byte_i) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && last_byte_i) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign src_ip_o         = res_q.src_ip;
  assign dst_ip_o         = res_q.dst_ip;
  assign src_port_o       = res_q.src_port;
  assign dst_port_o       = res_q.dst_port;
  assign payload_offset_o = res_q.payload_offset;
  assign payload_length_o = res_q.payload_length;

endmodule

// ===== verif/ipv4_tcp_header_extractor_tb.sv =====
module ipv4_tcp_header_extractor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ithe_pkg::*;

  localparam int unsigned WatchdogLimit = 5000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned FramesPerPhase = 3;

  localparam int FillZero   = 0;
  localparam int FillOnes   = 1;
  localparam int FillRandom = 2;

  class frame_scoreboard;
    int unsigned count;
    logic [3:0]  ip_version;
    logic [7:0]  protocol;
    logic [31:0] src_addr;
    logic [31:0] dst_addr;
    logic [15:0] src_port;
    logic [15:0] dst_port;
    logic [3:0]  data_off;
    result_t     expected_q[$];
    int unsigned errors;

    function new();
      errors = 0;
      clear_frame();
    endfunction

    function void clear_frame();
      count      = 0;
      ip_version = '0;
      protocol   = '0;
      src_addr   = '0;
      dst_addr   = '0;
      src_port   = '0;
      dst_port   = '0;
      data_off   = '0;
    endfunction

    function void note_byte(input logic [7:0] b, input logic last);
      int unsigned len;
      int unsigned offset;
      result_t r;
      if (count < DefMaxFrameBytes) begin
        if (count == PosVersion) ip_version = b[7:4];
        else if (count == PosProtocol) protocol = b;
        else if (count >= PosSrcIp && count < PosSrcIp + 4) src_addr = {src_addr[23:0], b};
        else if (count >= PosDstIp && count < PosDstIp + 4) dst_addr = {dst_addr[23:0], b};
        else if (count >= PosSrcPort && count < PosSrcPort + 2) src_port = {src_port[7:0], b};
        else if (count >= PosDstPort && count < PosDstPort + 2) dst_port = {dst_port[7:0], b};
        else if (count == PosDataOff) data_off = b[7:4];
        count++;
      end
      if (!last) return;
      len    = count;
      offset = EthHdrLen + IpHdrLen + 4 * data_off;
      r      = '0;
      if (len <= PosVersion) r.status = ST_BAD_LEN;
      else if (ip_version != IpVersion4) r.status = ST_NOT_IPV4;
      else if (len <= PosProtocol) r.status = ST_BAD_LEN;
      else if (protocol != ProtoTcp) r.status = ST_NOT_TCP;
      else if (len <= PosDataOff) r.status = ST_BAD_LEN;
      else if (offset >= len) r.status = ST_BAD_LEN;
      else begin
        r.status         = ST_OK;
        r.src_ip         = src_addr;
        r.dst_ip         = dst_addr;
        r.src_port       = src_port;
        r.dst_port       = dst_port;
        r.payload_offset = offset[OffsetW-1:0];
        r.payload_length = CountW'(len - offset);
      end
      expected_q.push_back(r);
      clear_frame();
    endfunction

    function void compare_field(input string name, input logic [31:0] want,
                                input logic [31:0] got);
      if (got !== want) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input result_t got);
      result_t want;
      if (expected_q.size() == 0) begin
        $error("result with no frame pending: status %0d", got.status);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      compare_field("status", want.status, got.status);
      compare_field("src_ip", want.src_ip, got.src_ip);
      compare_field("dst_ip", want.dst_ip, got.dst_ip);
      compare_field("src_port", want.src_port, got.src_port);
      compare_field("dst_port", want.dst_port, got.dst_port);
      compare_field("payload_offset", want.payload_offset, got.payload_offset);
      compare_field("payload_length", want.payload_length, got.payload_length);
    endfunction
  endclass

  logic               clk_i        = 1'b0;
  logic               rst_ni       = 1'b0;
  logic               in_valid_i   = 1'b0;
  logic               in_ready_o;
  logic [7:0]         frame_byte_i = '0;
  logic               last_byte_i  = 1'b0;
  logic               out_valid_o;
  logic               out_ready_i  = 1'b0;
  logic [1:0]         status_o;
  logic [31:0]        src_ip_o;
  logic [31:0]        dst_ip_o;
  logic [15:0]        src_port_o;
  logic [15:0]        dst_port_o;
  logic [OffsetW-1:0] payload_offset_o;
  logic [CountW-1:0]  payload_length_o;

  frame_scoreboard sb = new();
  int unsigned send_idle_pct  = 0;
  int unsigned recv_stall_pct = 0;
  int unsigned idle_cycles    = 0;

  ipv4_tcp_header_extractor u_top (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .frame_byte_i,
    .last_byte_i,
    .out_valid_o,
    .out_ready_i,
    .status_o,
    .src_ip_o,
    .dst_ip_o,
    .src_port_o,
    .dst_port_o,
    .payload_offset_o,
    .payload_length_o
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) sb.note_byte(frame_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i) begin
        sb.check_result('{status_e'(status_o), src_ip_o, dst_ip_o, src_port_o,
                          dst_port_o, payload_offset_o, payload_length_o});
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= WatchdogLimit) begin
        $display("FAILURE");
        $finish;
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    frame_byte_i <= b;
    last_byte_i  <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_frame(input int unsigned len, input logic [3:0] ver,
                            input logic [7:0] proto, input logic [3:0] doff,
                            input int fill);
    logic [7:0] b;
    for (int unsigned i = 0; i < len; i++) begin
      case (fill)
        FillZero: b = 8'h00;
        FillOnes: b = 8'hFF;
        default:  b = 8'($urandom_range(0, 255));
      endcase
      if (i == PosVersion) b[7:4] = ver;
      if (i == PosProtocol) b = proto;
      if (i == PosDataOff) b[7:4] = doff;
      push_byte(b, i == len - 1);
    end
  endtask

  task automatic send_random_frame();
    logic [3:0]  ver;
    logic [7:0]  proto;
    logic [3:0]  doff;
    int unsigned offset;
    int unsigned len;
    ver    = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(0, 15)) : IpVersion4;
    proto  = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : ProtoTcp;
    doff   = 4'($urandom_range(0, 15));
    offset = EthHdrLen + IpHdrLen + 4 * doff;
    if ($urandom_range(0, 9) < 2) len = $urandom_range(1, 60);
    else len = ((offset > PosDataOff + 1) ? offset : PosDataOff + 1) + $urandom_range(0, 40);
    send_frame(len, ver, proto, doff, FillRandom);
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic run_phase(input int unsigned idle_pct, input int unsigned stall_pct);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    for (int unsigned n = 0; n < FramesPerPhase; n++) send_random_frame();
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_frame(1, IpVersion4, ProtoTcp, 4'd0, FillZero);
    send_frame(PosVersion, IpVersion4, ProtoTcp, 4'd0, FillZero);
    send_frame(PosVersion + 1, 4'd5, ProtoTcp, 4'd0, FillZero);
    send_frame(PosVersion + 1, IpVersion4, ProtoTcp, 4'd0, FillZero);
    send_frame(PosProtocol, IpVersion4, ProtoTcp, 4'd0, FillZero);
    send_frame(PosProtocol + 1, IpVersion4, 8'd17, 4'd0, FillZero);
    send_frame(PosDataOff, IpVersion4, ProtoTcp, 4'd0, FillZero);
    send_frame(PosDataOff + 1, IpVersion4, ProtoTcp, 4'd0, FillZero);
    send_frame(95, IpVersion4, ProtoTcp, 4'hF, FillOnes);
    send_frame(94, IpVersion4, ProtoTcp, 4'hF, FillOnes);
    send_frame(60, 4'hF, 8'hFF, 4'hF, FillOnes);
    send_frame(60, IpVersion4, 8'hFF, 4'hF, FillOnes);
    send_frame(54, IpVersion4, ProtoTcp, 4'd5, FillRandom);
    wait_drained();

    run_phase(0, 0);
    run_phase(59, 0);
    wait_drained();
    run_phase(0, 59);
    run_phase(9, 9);
    run_phase(0, 0);

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.errors == 0 && sb.expected_q.size() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
